/* hw/rtl/pip_pkg.sv */
// Shared types and constants of the point-in-polygon tester.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

	// Vertex store geometry and coordinate format (4 fraction bits).
	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 20;
	localparam int IDX_BITS     = $clog2(MAX_VERTICES);
	localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
	localparam int MIN_VERTICES = 3;

	// Differences of two coordinates, and products of two differences.
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * DIFF_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic [IDX_BITS-1:0]          idx_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;

	typedef enum logic [1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_APPEND   = 2'd1,
		CMD_QUERY    = 2'd2,
		CMD_RESERVED = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_TOO_FEW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_WAIT
	} state_t;

	// Control that travels alongside one edge through the test pipeline.
	typedef struct packed {
		logic valid;
		logic last;
	} edge_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/pip_if.sv */
// Request and response channel interfaces of the point-in-polygon tester.
// Depends on pip_pkg for the coordinate width.
`timescale 1ns / 1ps
`default_nettype none

interface pip_req_if;
	import pip_pkg::*;

	logic         valid;
	logic         ready;
	logic [1:0]   command;
	coord_t       coord_x;
	coord_t       coord_y;

	modport source (output valid, command, coord_x, coord_y, input ready);
	modport sink   (input valid, command, coord_x, coord_y, output ready);
endinterface

interface pip_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       inside_res;

	modport source (output valid, status, inside_res, input ready);
	modport sink   (input valid, status, inside_res, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pip_edge_test.sv */
// Pipelined crossing test for one polygon edge against the query point.
// Depends on pip_pkg; instantiated by point_in_polygon_test.
`timescale 1ns / 1ps
`default_nettype none

module pip_edge_test (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pip_pkg::edge_ctl_t  ctl_in,
	input  pip_pkg::coord_t     pt_x,
	input  pip_pkg::coord_t     pt_y,
	input  pip_pkg::coord_t     a_x,
	input  pip_pkg::coord_t     a_y,
	input  pip_pkg::coord_t     b_x,
	input  pip_pkg::coord_t     b_y,
	output pip_pkg::edge_ctl_t  ctl_out,
	output logic                toggle
);
	import pip_pkg::*;

	edge_ctl_t ctl_s2, ctl_s3;
	diff_t     dxp_s2, dy_s2, dxb_s2, dyp_s2;
	logic      cross_s2, cross_s3;
	prod_t     p1_s3, p2_s3;
	logic      dypos_s3;

	// Stage control: valid and last flags move one stage per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_in;
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 2: coordinate differences and the straddle test on y.
	always_ff @(posedge clk) begin
		dxp_s2   <= diff_t'(pt_x) - diff_t'(a_x);
		dy_s2    <= diff_t'(b_y) - diff_t'(a_y);
		dxb_s2   <= diff_t'(b_x) - diff_t'(a_x);
		dyp_s2   <= diff_t'(pt_y) - diff_t'(a_y);
		cross_s2 <= (a_y > pt_y) != (b_y > pt_y);
	end

	// Stage 3: the two cross products that replace the division.
	always_ff @(posedge clk) begin
		p1_s3    <= prod_t'(dxp_s2) * prod_t'(dy_s2);
		p2_s3    <= prod_t'(dxb_s2) * prod_t'(dyp_s2);
		dypos_s3 <= !dy_s2[DIFF_BITS-1];
		cross_s3 <= cross_s2;
	end

	// A straddling edge has a non-zero y difference, so its sign alone
	// decides which way the comparison must point.
	assign ctl_out = ctl_s3;
	assign toggle  = cross_s3 && (dypos_s3 ? (p1_s3 < p2_s3) : (p1_s3 > p2_s3));

endmodule

`default_nettype wire

/* hw/rtl/point_in_polygon_test.sv */
// Point-in-polygon tester: clear and append are answered from the idle state; a query
// on n stored vertices reads n + 1 entries, one per cycle from the vertex memory,
// then drains the edge pipeline (stages s2 and s3) before it answers. One request is
// in progress at a time; the response register lets a new request in while the
// previous response is being taken.
// Reset clears the vertex count and control state; the memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test (
	input  wire        clk,
	input  wire        arst_n,
	pip_req_if.sink    req,
	pip_rsp_if.source  rsp
);
	import pip_pkg::*;

	// Vertex memory: x in the upper half of each word, y in the lower.
	logic [2*COORD_BITS-1:0] vmem [MAX_VERTICES];
	logic [2*COORD_BITS-1:0] rd_data_s1;

	state_t    state_q, state_d;
	cnt_t      count_q, count_d;
	cnt_t      step_q, step_d;
	coord_t    pt_x_q, pt_y_q;
	coord_t    prev_x_q, prev_y_q;
	logic      inside_q;
	logic      out_v_q;
	status_t   out_status_q, out_status_d;
	logic      out_inside_q, out_inside_d;
	logic      out_load, out_take;

	logic      req_fire, start_query;
	logic      rd_en, wr_en;
	idx_t      rd_addr;
	edge_ctl_t rd_ctl, ctl_s1, edge_ctl, done_ctl;
	logic      first_s1;
	logic      first_rd;
	logic      edge_toggle;
	coord_t    cur_x, cur_y;

	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && (!out_v_q || rsp.ready);
	assign out_take = out_v_q && rsp.ready;

	// Next state, memory access and response selection.
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		step_d       = step_q;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = '0;
		first_rd     = 1'b0;
		rd_ctl       = '0;
		start_query  = 1'b0;
		out_load     = 1'b0;
		out_status_d = STATUS_OK;
		out_inside_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					out_load = 1'b1;
					case (req.command)
						CMD_CLEAR: begin
							count_d = '0;
						end
						CMD_APPEND: begin
							if (count_q < cnt_t'(MAX_VERTICES)) begin
								wr_en   = 1'b1;
								count_d = count_q + cnt_t'(1);
							end else begin
								out_status_d = STATUS_FULL;
							end
						end
						CMD_QUERY: begin
							if (count_q < cnt_t'(MIN_VERTICES)) begin
								out_status_d = STATUS_TOO_FEW;
							end else begin
								out_load    = 1'b0;
								start_query = 1'b1;
								step_d      = '0;
								state_d     = ST_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				// The last vertex is read first so that it closes the polygon.
				rd_en        = 1'b1;
				first_rd     = (step_q == '0);
				rd_ctl.valid = 1'b1;
				rd_ctl.last  = (step_q == count_q);
				if (first_rd) begin
					rd_addr = idx_t'(count_q - cnt_t'(1));
				end else begin
					rd_addr = idx_t'(step_q - cnt_t'(1));
				end
				step_d = step_q + cnt_t'(1);
				if (rd_ctl.last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (done_ctl.valid && done_ctl.last) begin
					out_load     = 1'b1;
					out_inside_d = inside_q ^ edge_toggle;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			step_q   <= '0;
			ctl_s1   <= '0;
			first_s1 <= 1'b0;
			out_v_q  <= 1'b0;
			inside_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			step_q   <= step_d;
			ctl_s1   <= rd_ctl;
			first_s1 <= first_rd;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_take) begin
				out_v_q <= 1'b0;
			end
			if (start_query) begin
				inside_q <= 1'b0;
			end else if (done_ctl.valid) begin
				inside_q <= inside_q ^ edge_toggle;
			end
		end
	end

	// Vertex memory: one write port for appends, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			vmem[idx_t'(count_q)] <= {req.coord_x, req.coord_y};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= vmem[rd_addr];
		end
	end

	// Query point and the previously read vertex, which ends the edge.
	assign cur_x = rd_data_s1[2*COORD_BITS-1:COORD_BITS];
	assign cur_y = rd_data_s1[COORD_BITS-1:0];

	always_ff @(posedge clk) begin
		if (start_query) begin
			pt_x_q <= req.coord_x;
			pt_y_q <= req.coord_y;
		end
		if (ctl_s1.valid) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
	end

	// The first read only primes the previous vertex and forms no edge.
	always_comb begin
		edge_ctl       = ctl_s1;
		edge_ctl.valid = ctl_s1.valid && !first_s1;
	end

	pip_edge_test u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (edge_ctl),
		.pt_x    (pt_x_q),
		.pt_y    (pt_y_q),
		.a_x     (cur_x),
		.a_y     (cur_y),
		.b_x     (prev_x_q),
		.b_y     (prev_y_q),
		.ctl_out (done_ctl),
		.toggle  (edge_toggle)
	);

	// Response register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_inside_q <= out_inside_d;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.status     = out_status_q;
	assign rsp.inside_res = out_inside_q;

endmodule

`default_nettype wire
